[design/rrp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrp_pkg: shared types and constants
// Operation codes and sequencer states of the residue power block.
// ----------------------------------------------------------------------------
package rrp_pkg;

   localparam int EXP_BITS = 32;

   typedef enum logic {
      OP_POWER     = 1'b0,
      OP_NORMALIZE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_MUL,
      ST_SQR,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MM_REDUCE,
      MM_MUL,
      MM_SQR
   } mm_op_type;

   typedef struct packed {
      logic      start;
      mm_op_type op;
   } mm_ctrl_type;

endpackage : rrp_pkg
`default_nettype wire

[design/rrp_mulmod.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrp_mulmod: bit-serial modular multiplier for one lane
// Interleaved shift-add-reduce, one multiplier bit per cycle, MSB first.
// Reduce op computes base * 1 mod m. Modulus zero gives the truncated product.
// ----------------------------------------------------------------------------
module rrp_mulmod #(
   parameter int W = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rrp_pkg::mm_ctrl_type ctrl,
   input  wire logic [W-1:0]         acc_val,
   input  wire logic [W-1:0]         base_val,
   input  wire logic [W-1:0]         modulus,
   output logic [W-1:0]              result,
   output logic                      done
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  a_ff, a_in;
   logic [W-1:0]  b_ff, b_in;
   logic [W-1:0]  p_ff, p_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic [W+1:0]  dbl, dsub, add, asub;
   logic [W-1:0]  pd;

   always_comb begin
      dbl  = {1'b0, p_ff, 1'b0};
      dsub = dbl - {2'b00, modulus};
      if (modulus == '0) begin
         pd = dbl[W-1:0];
      end else if (!dsub[W+1]) begin
         pd = dsub[W-1:0];
      end else begin
         pd = dbl[W-1:0];
      end
      add  = {2'b00, pd} + (b_ff[W-1] ? {2'b00, a_ff} : '0);
      asub = add - {2'b00, modulus};
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      p_in    = p_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         busy_in = 1'b1;
         p_in    = '0;
         cnt_in  = CW'(W);
         unique case (ctrl.op)
            rrp_pkg::MM_REDUCE: begin
               // shift the unreduced value in bit by bit against constant one
               a_in = W'(1);
               b_in = base_val;
               cnt_in = CW'(W);
            end
            rrp_pkg::MM_MUL: begin
               a_in = acc_val;
               b_in = base_val;
            end
            default: begin
               a_in = base_val;
               b_in = base_val;
            end
         endcase
      end else if (busy_ff) begin
         if (modulus == '0) begin
            p_in = add[W-1:0];
         end else if (!asub[W+1]) begin
            p_in = asub[W-1:0];
         end else begin
            p_in = add[W-1:0];
         end
         b_in   = {b_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      p_ff <= p_in;
   end

   assign result = p_ff;
   assign done   = done_ff;
endmodule : rrp_mulmod
`default_nettype wire

[design/rrp_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrp_lane: accumulator and base registers of one residue lane
// Holds the running product and the squared base around the serial multiplier.
// ----------------------------------------------------------------------------
module rrp_lane #(
   parameter int W = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rrp_pkg::mm_ctrl_type ctrl,
   input  wire logic                 load,
   input  wire logic [W-1:0]         residue,
   input  wire logic [W-1:0]         modulus,
   output logic [W-1:0]              acc,
   output logic [W-1:0]              base,
   output logic                      done
);
   logic [W-1:0]      acc_ff, acc_in;
   logic [W-1:0]      base_ff, base_in;
   rrp_pkg::mm_op_type op_ff;
   logic [W-1:0]      mm_res;
   logic              mm_done;

   rrp_mulmod #(.W(W)) u_mm (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .acc_val  (acc_in),
      .base_val (base_in),
      .modulus  (modulus),
      .result   (mm_res),
      .done     (mm_done)
   );

   always_comb begin
      acc_in  = acc_ff;
      base_in = base_ff;
      if (load) begin
         base_in = residue;
         acc_in  = (modulus == W'(1)) ? '0 : W'(1);
      end else if (mm_done) begin
         unique case (op_ff)
            rrp_pkg::MM_MUL: acc_in  = mm_res;
            default:         base_in = mm_res;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= rrp_pkg::MM_REDUCE;
      end else if (ctrl.start) begin
         op_ff <= ctrl.op;
      end
      acc_ff  <= acc_in;
      base_ff <= base_in;
   end

   assign acc  = acc_ff;
   assign base = base_ff;
   assign done = mm_done;
endmodule : rrp_lane
`default_nettype wire

[design/rns_residue_power.sv]
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one item at a time; each modular product is a bit-serial
//   shift-add-reduce loop, shared by squaring and multiply.
// Reset: synchronous; moduli return to their defaults, sequencer to idle.
// ----------------------------------------------------------------------------
// rns_residue_power: per-lane modular exponentiation or normalization of an RNS vector
// Square-and-multiply sequencer over LANES bit-serial modular multipliers.
// ----------------------------------------------------------------------------
module rns_residue_power #(
   parameter int LANES        = 4,
   parameter int RESIDUE_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   // tdata: residue_0 .. residue_{LANES-1}, exponent; tuser: operation
   input  wire logic [((LANES*RESIDUE_BITS+rrp_pkg::EXP_BITS+7)/8)*8-1:0] req_tdata,
   input  wire logic                                       req_tuser,
   input  wire logic                                       req_tvalid,
   output logic                                            req_tready,
   // tdata: out_0 .. out_{LANES-1}
   output logic [((LANES*RESIDUE_BITS+7)/8)*8-1:0]         rsp_tdata,
   output logic                                            rsp_tvalid,
   input  wire logic                                       rsp_tready,
   input  wire logic                                       csr_we,
   input  wire logic [$clog2(LANES+1)-1:0]                 csr_index,
   input  wire logic [RESIDUE_BITS-1:0]                    csr_wdata
);
   localparam int W   = RESIDUE_BITS;
   localparam int EB  = rrp_pkg::EXP_BITS;
   localparam int OW  = ((LANES*W+7)/8)*8;

   logic [W-1:0] prime_ff [LANES];
   logic [W-1:0] res_in_w [LANES];
   logic [W-1:0] acc_w    [LANES];
   logic [W-1:0] base_w   [LANES];
   logic [LANES-1:0] done_w;

   rrp_pkg::state_type   state_ff, state_in;
   rrp_pkg::op_type      op_ff, op_in;
   logic [EB-1:0]        exp_ff, exp_in;
   logic [LANES*W-1:0]   raw_ff, raw_in;
   logic [OW-1:0]        out_ff, out_in;
   logic                 ovalid_ff, ovalid_in;
   rrp_pkg::mm_ctrl_type ctrl;
   logic                 load;
   logic                 accept;
   logic                 pass_ff;

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      for (int k = 0; k < LANES; k++) begin
         if (reset) begin
            unique case (k)
               0:       prime_ff[k] <= W'(65521);
               1:       prime_ff[k] <= W'(65519);
               2:       prime_ff[k] <= W'(65497);
               3:       prime_ff[k] <= W'(65479);
               default: prime_ff[k] <= W'(65521);
            endcase
         end else if (csr_we && csr_index == ($clog2(LANES+1))'(k)) begin
            prime_ff[k] <= csr_wdata;
         end
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      assign res_in_w[g] = req_tdata[g*W +: W];
      rrp_lane #(.W(W)) u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .load    (load),
         .residue (res_in_w[g]),
         .modulus (prime_ff[g]),
         .acc     (acc_w[g]),
         .base    (base_w[g]),
         .done    (done_w[g])
      );
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      exp_in    = exp_ff;
      raw_in    = raw_ff;
      out_in    = out_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      ctrl      = '{start: 1'b0, op: rrp_pkg::MM_REDUCE};
      load      = 1'b0;
      req_tready = (state_ff == rrp_pkg::ST_IDLE);
      unique case (state_ff)
         rrp_pkg::ST_IDLE: begin
            if (accept) begin
               load   = 1'b1;
               op_in  = rrp_pkg::op_type'(req_tuser);
               exp_in = req_tdata[LANES*W +: EB];
               raw_in = req_tdata[LANES*W-1:0];
               ctrl   = '{start: 1'b1, op: rrp_pkg::MM_REDUCE};
               state_in = rrp_pkg::ST_REDUCE;
            end
         end
         rrp_pkg::ST_REDUCE: begin
            if (done_w[0]) begin
               if (op_ff == rrp_pkg::OP_NORMALIZE || exp_ff <= EB'(1)) begin
                  state_in = rrp_pkg::ST_DONE;
               end else if (exp_ff[0]) begin
                  ctrl = '{start: 1'b1, op: rrp_pkg::MM_MUL};
                  state_in = rrp_pkg::ST_MUL;
               end else begin
                  ctrl = '{start: 1'b1, op: rrp_pkg::MM_SQR};
                  state_in = rrp_pkg::ST_SQR;
               end
            end
         end
         rrp_pkg::ST_MUL: begin
            if (done_w[0]) begin
               if (exp_ff == EB'(1)) begin
                  state_in = rrp_pkg::ST_DONE;
               end else begin
                  ctrl = '{start: 1'b1, op: rrp_pkg::MM_SQR};
                  state_in = rrp_pkg::ST_SQR;
               end
            end
         end
         rrp_pkg::ST_SQR: begin
            if (done_w[0]) begin
               exp_in = exp_ff >> 1;
               if (exp_ff[1]) begin
                  ctrl = '{start: 1'b1, op: rrp_pkg::MM_MUL};
                  state_in = rrp_pkg::ST_MUL;
               end else begin
                  ctrl = '{start: 1'b1, op: rrp_pkg::MM_SQR};
                  state_in = rrp_pkg::ST_SQR;
               end
            end
         end
         rrp_pkg::ST_DONE: begin
            if (!ovalid_ff || rsp_tready) begin
               ovalid_in = 1'b1;
               out_in    = '0;
               for (int k = 0; k < LANES; k++) begin
                  if (op_ff == rrp_pkg::OP_NORMALIZE) begin
                     out_in[k*W +: W] = base_w[k];
                  end else if (exp_ff == '0) begin
                     out_in[k*W +: W] = W'(1);
                  end else if (pass_ff) begin
                     out_in[k*W +: W] = raw_ff[k*W +: W];
                  end else begin
                     out_in[k*W +: W] = acc_w[k];
                  end
               end
               state_in = rrp_pkg::ST_IDLE;
            end
         end
         default: state_in = rrp_pkg::ST_IDLE;
      endcase
   end

   // exponent one with no squaring taken: pass residues through unreduced
   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff <= 1'b0;
      end else if (accept) begin
         pass_ff <= (req_tuser == 1'b0) && (req_tdata[LANES*W +: EB] == EB'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rrp_pkg::ST_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
      end
      op_ff  <= op_in;
      exp_ff <= exp_in;
      raw_ff <= raw_in;
      out_ff <= out_in;
   end

   assign rsp_tdata  = out_ff;
   assign rsp_tvalid = ovalid_ff;

`ifndef NO_ASSERTIONS
   a_lanes_sync: assert property (@(posedge clock) disable iff (reset)
      done_w[0] |-> done_w == '1)
      else $error("lane multipliers out of step");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != rrp_pkg::ST_IDLE) |-> !req_tready)
      else $error("input taken while busy");
   a_done_to_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rrp_pkg::ST_DONE && state_in == rrp_pkg::ST_IDLE) |=> rsp_tvalid)
      else $error("result lost");
`endif
endmodule : rns_residue_power
`default_nettype wire

[tb/tb_rns_residue_power.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rns_residue_power: self-checking bench for the RNS residue power block
// Drives power and normalize requests with random gaps and response stalls,
// predicts each lane by square-and-multiply under the current moduli, and
// compares every response transfer in order. Moduli change between phases.
// ----------------------------------------------------------------------------
module tb_rns_residue_power;

   localparam int LANES   = 4;
   localparam int RB      = 16;
   localparam int REQ_W   = ((LANES*RB+32+7)/8)*8;
   localparam int RSP_W   = ((LANES*RB+7)/8)*8;
   localparam int IDX_W   = $clog2(LANES+1);
   localparam int LAT     = 2 + (RB+1)*65;
   localparam int WDOG    = 40*LAT;

   typedef struct {
      rrp_pkg::op_type op;
      logic [15:0]     res [LANES];
      logic [31:0]     expo;
   } req_item_type;

   typedef logic [RSP_W-1:0] rsp_word_type;

   logic              clock = 0;
   logic              reset = 1;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic              req_tuser = 0;
   logic              req_tvalid = 0;
   logic              req_tready;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready = 0;
   logic              csr_we = 0;
   logic [IDX_W-1:0]  csr_index = '0;
   logic [RB-1:0]     csr_wdata = '0;

   rns_residue_power dut (.*);

   req_item_type  pending_reqs [$];
   rsp_word_type  expected_rsps [$];
   logic [15:0] modulus [LANES];
   int  mismatches = 0;
   int  accepted = 0;
   int  received = 0;
   int  idle_cycles = 0;
   int  hold_off = 0;
   bit  rsp_gaps_on = 1;
   bit  req_fire = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [15:0] reduce16(logic [63:0] v, logic [15:0] m);
      if (m == 0) return v[15:0];
      return 16'(v % m);
   endfunction

   function automatic logic [15:0] lane_power(logic [15:0] b, logic [31:0] e,
                                              logic [15:0] m);
      logic [15:0] acc;
      logic [15:0] sq;
      acc = reduce16(1, m);
      sq  = reduce16(b, m);
      while (e != 0) begin
         if (e[0]) acc = reduce16(64'(acc) * 64'(sq), m);
         sq = reduce16(64'(sq) * 64'(sq), m);
         e = e >> 1;
      end
      return acc;
   endfunction

   function automatic rsp_word_type predict_residues(req_item_type it);
      rsp_word_type w;
      logic [15:0] v;
      w = '0;
      for (int k = 0; k < LANES; k++) begin
         if (it.op == rrp_pkg::OP_NORMALIZE) v = reduce16(it.res[k], modulus[k]);
         else if (it.expo == 0) v = 1;
         else if (it.expo == 1) v = it.res[k];
         else v = lane_power(it.res[k], it.expo, modulus[k]);
         w[k*RB +: RB] = v;
      end
      return w;
   endfunction

   function automatic int rand_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // record whether the last rising edge took the request
   always @(posedge clock) begin
      req_fire <= req_tvalid && req_tready;
   end

   // driver
   int tx_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && !req_fire) begin
            // hold
         end else if (tx_gap > 0) begin
            tx_gap <= tx_gap - 1;
            req_tvalid <= 0;
         end else if (pending_reqs.size() > 0) begin
            req_item_type it;
            logic [REQ_W-1:0] d;
            it = pending_reqs.pop_front();
            d = '0;
            for (int k = 0; k < LANES; k++) d[k*RB +: RB] = it.res[k];
            d[LANES*RB +: 32] = it.expo;
            req_tdata  <= d;
            req_tuser  <= it.op;
            req_tvalid <= 1;
            expected_rsps.push_back(predict_residues(it));
            tx_gap <= rand_gap();
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // receiver stall
   always @(negedge clock) begin
      if (reset) rsp_tready <= 0;
      else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 0;
      end else if (!rsp_gaps_on) rsp_tready <= 1;
      else rsp_tready <= (rand_gap() == 0);
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) accepted <= accepted + 1;
         if (rsp_tvalid && rsp_tready) begin
            received <= received + 1;
            if (expected_rsps.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("unexpected transfer %h", rsp_tdata);
            end else begin
               rsp_word_type e;
               e = expected_rsps.pop_front();
               if (e !== rsp_tdata) begin
                  if (mismatches < 10)
                     $display("mismatch rsp %0d: expected %h got %h",
                              received, e, rsp_tdata);
                  mismatches <= mismatches + 1;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WDOG) begin
            $display("watchdog expired");
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic write_modulus(int idx, logic [15:0] v);
      @(negedge clock);
      csr_we    <= 1;
      csr_index <= IDX_W'(idx);
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 0;
      @(posedge clock);
      modulus[idx] = v;
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (LAT) @(posedge clock);
   endtask

   task automatic queue_req(rrp_pkg::op_type op, logic [15:0] r0, logic [15:0] r1,
                            logic [15:0] r2, logic [15:0] r3, logic [31:0] e);
      req_item_type it;
      it.op = op;
      it.res[0] = r0; it.res[1] = r1; it.res[2] = r2; it.res[3] = r3;
      it.expo = e;
      pending_reqs.push_back(it);
   endtask

   task automatic queue_random(int n);
      for (int i = 0; i < n; i++) begin
         logic [31:0] e;
         int s;
         s = $urandom_range(0, 9);
         if (s == 0) e = $urandom_range(0, 1);
         else if (s < 5) e = $urandom_range(2, 40);
         else e = $urandom;
         queue_req(rrp_pkg::op_type'($urandom_range(0, 3) == 0), 16'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom), e);
      end
   endtask

   initial begin
      modulus[0] = 65521; modulus[1] = 65519;
      modulus[2] = 65497; modulus[3] = 65479;
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 0;

      // directed: reset moduli
      queue_req(rrp_pkg::OP_POWER, 16'hFFFF, 0, 16'h1234, 16'hFFF0, 0);
      queue_req(rrp_pkg::OP_POWER, 16'hFFFF, 0, 16'h1234, 16'hFFF0, 1);
      queue_req(rrp_pkg::OP_POWER, 16'hFFFF, 0, 3, 16'hFFC7, 2);
      queue_req(rrp_pkg::OP_POWER, 16'hFFFF, 1, 2, 7, 32'hFFFF_FFFF);
      queue_req(rrp_pkg::OP_POWER, 16'hAAAA, 16'h5555, 16'hFFFE, 65479, 32'h8000_0000);
      queue_req(rrp_pkg::OP_NORMALIZE, 16'hFFFF, 16'hFFF0, 0, 65479, 32'hFFFF_FFFF);
      queue_req(rrp_pkg::OP_NORMALIZE, 65521, 65519, 65497, 65478, 0);
      drain();

      // extremes: modulus 0, 1, 2, 65535
      write_modulus(0, 0);
      write_modulus(1, 1);
      write_modulus(2, 2);
      write_modulus(3, 16'hFFFF);
      queue_req(rrp_pkg::OP_POWER, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
      queue_req(rrp_pkg::OP_POWER, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
      queue_req(rrp_pkg::OP_POWER, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2);
      queue_req(rrp_pkg::OP_POWER, 3, 5, 3, 16'hFFFE, 32'hFFFF_FFFF);
      queue_req(rrp_pkg::OP_POWER, 16'h8001, 0, 4, 0, 32'h5555_5555);
      queue_req(rrp_pkg::OP_NORMALIZE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
      queue_req(rrp_pkg::OP_NORMALIZE, 0, 0, 1, 16'hFFFE, 0);
      queue_random(30);
      drain();

      // back pressure: stall receiver while sender keeps offering
      hold_off = 3*LAT;
      queue_random(8);
      drain();

      // random moduli
      for (int ph = 0; ph < 3; ph++) begin
         for (int k = 0; k < LANES; k++)
            write_modulus(k, (ph == 2) ? 16'($urandom_range(2, 20))
                                       : 16'($urandom_range(2, 65535)));
         rsp_gaps_on = (ph != 1);
         queue_random(80);
         drain();
      end

      $display("covered %0d requests, %0d responses, moduli 0/1/2/max and random",
               accepted, received);
      $display("power and normalize modes with exponents 0, 1, small and full range");
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

[files.f]
design/rrp_pkg.sv
design/rrp_mulmod.sv
design/rrp_lane.sv
design/rns_residue_power.sv
tb/tb_rns_residue_power.sv
